// ===== rtl/mrac_sm_pkg.sv =====
package mrac_sm_pkg;

  // Three adaptive gains per joint: position, velocity and reference terms.
  localparam int unsigned NumTerms = 3;
  localparam int unsigned TermW    = 2;
  localparam int unsigned JointW   = 3;
  localparam int unsigned SigW     = 32;
  localparam int unsigned GainW    = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;

  typedef enum logic [CfgIdxW-1:0] {
    CfgJointCount = 2'd0,
    CfgAdaptGain  = 2'd1,
    CfgLeakRate   = 2'd2,
    CfgGainLimit  = 2'd3
  } cfg_idx_e;

  // Sequencer steps, one-hot.
  typedef enum logic [7:0] {
    SIdle = 8'b0000_0001,
    SEphi = 8'b0000_0010,
    SQlo  = 8'b0000_0100,
    SQhi  = 8'b0000_1000,
    SLeak = 8'b0001_0000,
    SUpd  = 8'b0010_0000,
    SWb   = 8'b0100_0000,
    SOut  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [JointW-1:0]      joint;
    logic signed [SigW-1:0] position;
    logic signed [SigW-1:0] velocity;
    logic signed [SigW-1:0] reference;
  } in_word_t;

  typedef struct packed {
    logic [JointW-1:0]      joint_out;
    logic signed [SigW-1:0] adaptive_drive;
    logic                   status;
    logic                   saturated;
  } out_word_t;

  // Sequencer to datapath control.
  typedef struct packed {
    state_e           step;
    logic             load;
    logic [TermW-1:0] term;
    logic             acc_pend;
    logic             out_load;
  } ctl_t;

endpackage

// ===== rtl/mrac_sm_ram.sv =====
module mrac_sm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 24,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mrac_sm_ctrl.sv =====
module mrac_sm_ctrl import mrac_sm_pkg::*; #(
  parameter int unsigned MaxJoints = 8,
  localparam int unsigned Depth = MaxJoints * NumTerms,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [JointW-1:0] in_joint_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  logic [3:0]        joint_count_i,
  input  logic              clear_gains_i,
  output ctl_t              ctl_o,
  output logic [AddrW-1:0]  ram_addr_o,
  output logic              ram_we_o,
  output logic              ram_re_o,
  output logic              gain_valid_o,
  output logic [JointW-1:0] joint_o,
  output logic              bad_o
);

  localparam int unsigned RowW = (MaxJoints > 1) ? $clog2(MaxJoints) : 1;
  localparam logic [TermW-1:0] LastTerm = TermW'(NumTerms - 1);

  state_e              state_q, state_d;
  logic [TermW-1:0]    term_q, term_d;
  logic [JointW-1:0]   joint_q, joint_d;
  logic                bad_q, bad_d;
  logic                acc_pend_q;
  logic                out_valid_q, out_valid_d;
  logic [MaxJoints-1:0] valid_q, valid_d;
  logic                rd_valid_q;
  logic [RowW-1:0]     row;
  logic                accept;
  logic                in_ok;
  logic                out_load;

  assign in_ok  = ({1'b0, in_joint_i} < joint_count_i) && (int'(in_joint_i) < MaxJoints);
  assign accept = in_valid_i && (state_q == SIdle);
  assign row    = RowW'(joint_q);
  assign out_load = (state_q == SOut) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    joint_d = joint_q;
    bad_d   = bad_q;
    case (state_q)
      SIdle: begin
        if (accept) begin
          joint_d = in_joint_i;
          bad_d   = !in_ok;
          term_d  = '0;
          state_d = in_ok ? SEphi : SOut;
        end
      end
      SEphi: state_d = SQlo;
      SQlo:  state_d = SQhi;
      SQhi:  state_d = SLeak;
      SLeak: state_d = SUpd;
      SUpd:  state_d = SWb;
      SWb: begin
        if (term_q == LastTerm) begin
          state_d = SOut;
        end else begin
          term_d  = term_q + 1'b1;
          state_d = SEphi;
        end
      end
      SOut: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // A row becomes valid once all of its gains have been written back.
  always_comb begin
    valid_d = valid_q;
    if (clear_gains_i) begin
      valid_d = '0;
    end else if ((state_q == SWb) && (term_q == LastTerm)) begin
      valid_d[row] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      term_q      <= '0;
      joint_q     <= '0;
      bad_q       <= 1'b0;
      acc_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      joint_q     <= joint_d;
      bad_q       <= bad_d;
      acc_pend_q  <= (state_q == SWb);
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
      if (state_q == SEphi) begin
        rd_valid_q <= valid_q[row];
      end
    end
  end

  assign ram_addr_o = AddrW'(int'(joint_q) * int'(NumTerms) + int'(term_q));
  assign ram_re_o   = (state_q == SEphi);
  assign ram_we_o   = (state_q == SWb);

  assign ctl_o.step     = state_q;
  assign ctl_o.load     = accept;
  assign ctl_o.term     = term_q;
  assign ctl_o.acc_pend = acc_pend_q;
  assign ctl_o.out_load = out_load;

  assign in_ready_o   = (state_q == SIdle);
  assign out_valid_o  = out_valid_q;
  assign gain_valid_o = rd_valid_q;
  assign joint_o      = joint_q;
  assign bad_o        = bad_q;

endmodule

// ===== rtl/mrac_sm_dp.sv =====
module mrac_sm_dp import mrac_sm_pkg::*; (
  input  logic                   clk_i,
  input  ctl_t                   ctl_i,
  input  in_word_t               in_word_i,
  input  logic [23:0]            adapt_gain_i,
  input  logic [15:0]            leak_rate_i,
  input  logic [30:0]            gain_limit_i,
  input  logic [GainW-1:0]       gain_rdata_i,
  input  logic                   gain_valid_i,
  output logic [GainW-1:0]       gain_wdata_o,
  output logic signed [SigW-1:0] drive_o,
  output logic                   saturated_o
);

  localparam int unsigned OpW   = 33;
  localparam int unsigned ProdW = 2 * OpW;
  localparam logic signed [49:0] DrvMax = 50'sd2147483647;
  localparam logic signed [49:0] DrvMin = -50'sd2147483648;

  logic signed [SigW-1:0]  phi_q [NumTerms];
  logic signed [OpW-1:0]   e_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [49:0]      q_q;
  logic [47:0]             adlo_q;
  logic signed [GainW-1:0] g_q;
  logic signed [58:0]      t_q;
  logic signed [GainW-1:0] nv_q;
  logic signed [ProdW-1:0] acc_q;

  logic signed [SigW-1:0]  phi_k;
  logic signed [OpW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [25:0]      q_hi;
  logic signed [73:0]      qg;
  logic signed [57:0]      adapt;
  logic signed [31:0]      leak;
  logic signed [59:0]      nv_full, lim_s, neg_lim_s, nv_clamp;
  logic signed [ProdW-1:0] sum;
  logic signed [49:0]      drive_full;

  assign phi_k = phi_q[ctl_i.term];
  assign q_hi  = q_q[49:24];

  // One shared multiplier, operands picked per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl_i.step)
      SEphi: begin
        mul_a = e_q;
        mul_b = OpW'(phi_k);
      end
      SQlo: begin
        mul_a = {9'b0, prod_q[39:16]};
        mul_b = {9'b0, adapt_gain_i};
      end
      SQhi: begin
        mul_a = OpW'(q_hi);
        mul_b = {9'b0, adapt_gain_i};
      end
      SLeak: begin
        mul_a = {17'b0, leak_rate_i};
        mul_b = OpW'(g_q);
      end
      SWb: begin
        mul_a = OpW'(nv_q);
        mul_b = OpW'(phi_k);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // The full adaptation product is the high partial product shifted up plus the low one.
  assign qg    = {prod_q[49:0], 24'b0} + {26'b0, adlo_q};
  assign adapt = qg[73:16];

  assign leak      = prod_q[47:16];
  assign nv_full   = 60'(t_q) - 60'(leak);
  assign lim_s     = {29'b0, gain_limit_i};
  assign neg_lim_s = -lim_s;

  always_comb begin
    nv_clamp = nv_full;
    if (nv_full > lim_s) begin
      nv_clamp = lim_s;
    end
    if (nv_full < neg_lim_s) begin
      nv_clamp = neg_lim_s;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (ctl_i.load) begin
      phi_q[0] <= in_word_i.position;
      phi_q[1] <= in_word_i.velocity;
      phi_q[2] <= in_word_i.reference;
      e_q      <= OpW'(in_word_i.position) - OpW'(in_word_i.reference);
      acc_q    <= '0;
    end else if (ctl_i.acc_pend) begin
      acc_q <= acc_q + prod_q;
    end
    if (ctl_i.step == SQlo) begin
      q_q <= prod_q[65:16];
      g_q <= gain_valid_i ? gain_rdata_i : '0;
    end
    if (ctl_i.step == SQhi) begin
      adlo_q <= prod_q[47:0];
    end
    if (ctl_i.step == SLeak) begin
      t_q <= 59'(g_q) - 59'(adapt);
    end
    if (ctl_i.step == SUpd) begin
      nv_q <= nv_clamp[31:0];
    end
  end

  assign gain_wdata_o = nv_q;

  // The last product may still be on its way into the accumulator.
  assign sum        = acc_q + (ctl_i.acc_pend ? prod_q : '0);
  assign drive_full = sum[65:16];

  always_comb begin
    saturated_o = 1'b0;
    drive_o     = drive_full[31:0];
    if (drive_full > DrvMax) begin
      drive_o     = DrvMax[31:0];
      saturated_o = 1'b1;
    end
    if (drive_full < DrvMin) begin
      drive_o     = DrvMin[31:0];
      saturated_o = 1'b1;
    end
  end

endmodule

// ===== rtl/mrac_sigma_mod_adaptive_law.sv =====
// Channel   Direction  Handshake              Word
// input     in         in_valid_i/in_ready_o  in_word_t: joint, position, velocity, reference
// output    out        out_valid_o/out_ready_i out_word_t: joint_out, adaptive_drive, status,
//                                             saturated
// config    in         cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// An in-range word runs six steps per gain on the one shared 33x33 multiplier for each of
// three gains, between acceptance in SIdle and the result step SOut. A word with an
// out-of-range joint goes from SIdle straight to SOut. Reset and a write of joint_count clear
// one valid bit per joint row at once, so there is no clearing pass. A finished result waits
// in the output register and the next word is accepted meanwhile; the block stalls only when a
// second result is ready before the first one has been taken.
module mrac_sigma_mod_adaptive_law import mrac_sm_pkg::*; #(
  parameter int unsigned MaxJoints = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MaxJoints * NumTerms;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Configuration registers. Gamma is unsigned Q8.16, sigma unsigned Q0.16 and the gain
  // limit an unsigned Q15.16 bound.
  logic [3:0]  joint_count_q;
  logic [23:0] adapt_gain_q;
  logic [15:0] leak_rate_q;
  logic [30:0] gain_limit_q;
  logic        clear_gains;

  assign clear_gains = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CfgJointCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_count_q <= '0;
      adapt_gain_q  <= '0;
      leak_rate_q   <= '0;
      gain_limit_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgJointCount: joint_count_q <= cfg_data_i[3:0];
        CfgAdaptGain:  adapt_gain_q  <= cfg_data_i[23:0];
        CfgLeakRate:   leak_rate_q   <= cfg_data_i[15:0];
        CfgGainLimit:  gain_limit_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  ctl_t              ctl;
  logic [AddrW-1:0]  ram_addr;
  logic              ram_we, ram_re;
  logic [GainW-1:0]  ram_rdata, ram_wdata;
  logic              gain_valid;
  logic [JointW-1:0] joint;
  logic              bad;
  logic signed [SigW-1:0] drive;
  logic              saturated;

  mrac_sm_ctrl #(
    .MaxJoints(MaxJoints)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_joint_i   (in_word_i.joint),
    .in_ready_o   (in_ready_o),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .joint_count_i(joint_count_q),
    .clear_gains_i(clear_gains),
    .ctl_o        (ctl),
    .ram_addr_o   (ram_addr),
    .ram_we_o     (ram_we),
    .ram_re_o     (ram_re),
    .gain_valid_o (gain_valid),
    .joint_o      (joint),
    .bad_o        (bad)
  );

  // Gain store: one row of three gains per joint.
  mrac_sm_ram #(
    .Width(GainW),
    .Depth(Depth)
  ) u_gain_ram (
    .clk_i  (clk_i),
    .addr_i (ram_addr),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  mrac_sm_dp u_dp (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .in_word_i   (in_word_i),
    .adapt_gain_i(adapt_gain_q),
    .leak_rate_i (leak_rate_q),
    .gain_limit_i(gain_limit_q),
    .gain_rdata_i(ram_rdata),
    .gain_valid_i(gain_valid),
    .gain_wdata_o(ram_wdata),
    .drive_o     (drive),
    .saturated_o (saturated)
  );

  // Output register. An out-of-range joint reports status and a zero drive.
  out_word_t out_word_q;

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_word_q.joint_out      <= joint;
      out_word_q.status         <= bad;
      out_word_q.adaptive_drive <= bad ? '0 : drive;
      out_word_q.saturated      <= bad ? 1'b0 : saturated;
    end
  end

  assign out_word_o = out_word_q;

endmodule
